// ----- rtl/assert_macros.svh -----
// Assertion helpers, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is active (low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that one condition implies another in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, (pre) |-> (post), msg)

`endif

// ----- rtl/mfdo_pkg.sv -----
// ----------------------------------------------------------------------------
// mfdo_pkg
// Shared types, constants and face pattern tables for the face dedup block.
// ----------------------------------------------------------------------------
package mfdo_pkg;

  // Table and vertex sizing; TABLE_ENTRIES must be a power of two
  localparam int TABLE_ENTRIES = 4096;
  localparam int VERTEX_BITS   = 16;
  localparam int MAX_CONE      = 8;

  localparam int SLOT_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int HASH_W   = 32 + SLOT_W;
  localparam int KEY_W    = 64;
  localparam int FNUM_W   = 16;
  localparam int CREATE_W = 13;
  localparam int ENTRY_W  = 1 + KEY_W + KEY_W + FNUM_W;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  // Configuration register indexes
  localparam logic CFG_DIM  = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  typedef enum logic [2:0] {
    ERR_OK, ERR_SHAPE, ERR_SIZE, ERR_ORIENT, ERR_FULL
  } err_t;

  typedef enum logic [2:0] {
    SHAPE_NONE, SHAPE_TRI, SHAPE_QUAD, SHAPE_TET, SHAPE_HEX
  } shape_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_FACE, ST_HASH, ST_SEED, ST_READ, ST_CHECK, ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic load_cell;
    logic err_shape;
    logic err_size;
    logic start;
    logic load_face;
    logic hash_step;
    logic seed;
    logic rd;
    logic check;
    logic next_face;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic shape_ok;
    logic size_ok;
    logic hash_done;
    logic probe_done;
    logic last;
  } sts_t;

  localparam logic [2:0] PAT_TRI  [3][2] = '{'{0, 1}, '{1, 2}, '{2, 0}};
  localparam logic [2:0] PAT_QUAD [4][2] = '{'{0, 1}, '{1, 2}, '{2, 3}, '{3, 0}};
  localparam logic [2:0] PAT_TET  [4][3] = '{'{0, 1, 2}, '{0, 3, 1}, '{0, 2, 3}, '{2, 1, 3}};
  localparam logic [2:0] PAT_HEX  [6][4] = '{'{0, 1, 2, 3}, '{4, 5, 6, 7}, '{0, 3, 5, 4},
                                             '{2, 1, 7, 6}, '{3, 2, 6, 5}, '{0, 4, 7, 1}};

  function automatic shape_t shape_decode(logic [1:0] dim, logic [3:0] cs);
    shape_t s;
    s = SHAPE_NONE;
    if (dim == 2'd2 && cs == 4'd3) s = SHAPE_TRI;
    else if (dim == 2'd2 && cs == 4'd4) s = SHAPE_QUAD;
    else if (dim == 2'd3 && cs == 4'd3) s = SHAPE_TRI;
    else if (dim == 2'd3 && cs == 4'd4) s = SHAPE_TET;
    else if (dim == 2'd3 && cs == 4'd8) s = SHAPE_HEX;
    return s;
  endfunction

  function automatic logic [2:0] face_count(shape_t s);
    logic [2:0] n;
    unique case (s)
      SHAPE_TRI:  n = 3'd3;
      SHAPE_QUAD: n = 3'd4;
      SHAPE_TET:  n = 3'd4;
      SHAPE_HEX:  n = 3'd6;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] face_size(shape_t s);
    logic [2:0] n;
    unique case (s)
      SHAPE_TRI:  n = 3'd2;
      SHAPE_QUAD: n = 3'd2;
      SHAPE_TET:  n = 3'd3;
      SHAPE_HEX:  n = 3'd4;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  // Cone position of vertex a of face f
  function automatic logic [2:0] pat_vertex(shape_t s, logic [2:0] f, logic [1:0] a);
    logic [2:0] v;
    v = 3'd0;
    unique case (s)
      SHAPE_TRI:  if (f < 3'd3 && a < 2'd2) v = PAT_TRI[f[1:0]][a[0]];
      SHAPE_QUAD: if (f < 3'd4 && a < 2'd2) v = PAT_QUAD[f[1:0]][a[0]];
      SHAPE_TET:  if (f < 3'd4 && a < 2'd3) v = PAT_TET[f[1:0]][a];
      SHAPE_HEX:  if (f < 3'd6) v = PAT_HEX[f][a];
      default:    v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/mesh_face_dedup_orient.sv -----
// ----------------------------------------------------------------------------
// mesh_face_dedup_orient
// Per-cell face lookup in a hashed face table with orientation results.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  in      | in_valid/in_stall, in_cone_size,     | cell item in
//          | in_vertex_0..7                      |
//  out     | out_valid/out_stall, face fields    | one item per face out
//  cfg     | cfg_we, cfg_index, cfg_data         | register write in
//
// A cell is checked in SETUP, then each face has a gather step, a hash
// multiply step per 16-bit key slice, a seed step, a READ and CHECK pair
// per table probe (registered RAM read) and an emit step.
// After reset a clearing pass writes all 4096 table entries, one a cycle;
// no cell is taken during it. Configuration writes are taken at any time.
// A stalled result holds the block; the next cell is taken after the last.
module mesh_face_dedup_orient
  import mfdo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_cone_size,
  input  logic [15:0]       in_vertex_0,
  input  logic [15:0]       in_vertex_1,
  input  logic [15:0]       in_vertex_2,
  input  logic [15:0]       in_vertex_3,
  input  logic [15:0]       in_vertex_4,
  input  logic [15:0]       in_vertex_5,
  input  logic [15:0]       in_vertex_6,
  input  logic [15:0]       in_vertex_7,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_face_number,
  output logic              out_is_new,
  output logic signed [2:0] out_orientation,
  output logic [2:0]        out_local_face,
  output logic              out_last_face,
  output logic [2:0]        out_error_code
);

`include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  mfdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfdo_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_cone_size    (in_cone_size),
    .in_vertex_0     (in_vertex_0),
    .in_vertex_1     (in_vertex_1),
    .in_vertex_2     (in_vertex_2),
    .in_vertex_3     (in_vertex_3),
    .in_vertex_4     (in_vertex_4),
    .in_vertex_5     (in_vertex_5),
    .in_vertex_6     (in_vertex_6),
    .in_vertex_7     (in_vertex_7),
    .cmd             (cmd),
    .sts             (sts),
    .out_face_number (out_face_number),
    .out_is_new      (out_is_new),
    .out_orientation (out_orientation),
    .out_local_face  (out_local_face),
    .out_last_face   (out_last_face),
    .out_error_code  (out_error_code)
  );

  // No cell taken while a result waits
  `ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, in_stall, "cell taken during result")
  // Cell-level errors end the cell
  `ASSERT_IMPL(a_err_last, clk, rst_n,
    out_valid && (out_error_code == ERR_SHAPE || out_error_code == ERR_SIZE),
    out_last_face, "cell error not marked last")
  // New faces carry no orientation and no error
  `ASSERT_IMPL(a_new_clean, clk, rst_n, out_valid && out_is_new,
    out_orientation == 3'sd0 && out_error_code == ERR_OK, "new face with orientation")

endmodule

// ----- rtl/mfdo_ram.sv -----
// ----------------------------------------------------------------------------
// mfdo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/mfdo_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfdo_ctrl
// Sequencer: table clear, cell checks, per-face hash, probe and emit steps.
// ----------------------------------------------------------------------------
module mfdo_ctrl
  import mfdo_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_cell = 1'b1;
          state_nxt     = ST_SETUP;
        end
      end
      ST_SETUP: begin
        priority if (!sts.shape_ok) begin
          cmd.err_shape = 1'b1;
          state_nxt     = ST_EMIT;
        end else if (!sts.size_ok) begin
          cmd.err_size = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_FACE;
        end
      end
      ST_FACE: begin
        cmd.load_face = 1'b1;
        state_nxt     = ST_HASH;
      end
      ST_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) state_nxt = ST_SEED;
      end
      ST_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.probe_done ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_face = 1'b1;
            state_nxt     = ST_FACE;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

// ----- rtl/mfdo_dp.sv -----
// ----------------------------------------------------------------------------
// mfdo_dp
// Datapath: configuration, cell and face registers, hash, face table, results.
// ----------------------------------------------------------------------------
module mfdo_dp
  import mfdo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [3:0]        in_cone_size,
  input  logic [15:0]       in_vertex_0,
  input  logic [15:0]       in_vertex_1,
  input  logic [15:0]       in_vertex_2,
  input  logic [15:0]       in_vertex_3,
  input  logic [15:0]       in_vertex_4,
  input  logic [15:0]       in_vertex_5,
  input  logic [15:0]       in_vertex_6,
  input  logic [15:0]       in_vertex_7,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [15:0]       out_face_number,
  output logic              out_is_new,
  output logic signed [2:0] out_orientation,
  output logic [2:0]        out_local_face,
  output logic              out_last_face,
  output logic [2:0]        out_error_code
);

  typedef logic [15:0] vtx_t;

  // Sort four values ascending with a five-stage compare-swap network
  function automatic void sort4(input vtx_t a [4], output vtx_t o [4]);
    vtx_t t;
    o = a;
    if (o[0] > o[1]) begin t = o[0]; o[0] = o[1]; o[1] = t; end
    if (o[2] > o[3]) begin t = o[2]; o[2] = o[3]; o[3] = t; end
    if (o[0] > o[2]) begin t = o[0]; o[0] = o[2]; o[2] = t; end
    if (o[1] > o[3]) begin t = o[1]; o[1] = o[3]; o[3] = t; end
    if (o[1] > o[2]) begin t = o[1]; o[1] = o[2]; o[2] = t; end
  endfunction

  // Orientation of the cell's face order against the stored order
  function automatic logic [3:0] orient(input vtx_t fv [4], input vtx_t cv [4],
                                        input logic [2:0] fs);
    logic [2:0] i, idx;
    logic       found, fwd, bwd;
    logic [2:0] o;
    i     = 3'd0;
    found = 1'b0;
    for (int a = 3; a >= 0; a--) begin
      if (3'(a) < fs && fv[0] == cv[a]) begin
        i     = 3'(a);
        found = 1'b1;
      end
    end
    fwd = found;
    bwd = found;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < fs) begin
        idx = i + 3'(j);
        if (idx >= fs) idx = idx - fs;
        if (fv[j] != cv[idx[1:0]]) fwd = 1'b0;
        idx = i + fs - 3'(j);
        if (idx >= fs) idx = idx - fs;
        if (fv[j] != cv[idx[1:0]]) bwd = 1'b0;
      end
    end
    o = 3'd0;
    priority if (fwd) o = (fs == 3'd2 && i == 3'd1) ? 3'b110 : i;
    else if (bwd) o = (i == 3'd0) ? 3'(-fs) : 3'(-i);
    else o = 3'd0;
    return {~(fwd | bwd), o};
  endfunction

  logic [1:0]             dim_r;
  logic [15:0]            base_r;
  logic [CREATE_W-1:0]    created_r;
  logic [2:0]             seen_r;
  logic [3:0]             cs_r;
  logic [VERTEX_BITS-1:0] vert_r [MAX_CONE];
  shape_t                 shape_r;
  logic [2:0]             fsize_r, nfaces_r, face_r;
  vtx_t                   fv_r [4];
  logic [KEY_W-1:0]       key_r, order_r;
  logic [HASH_W-1:0]      acc_r;
  logic [1:0]             hidx_r;
  logic [SLOT_W-1:0]      slot_r, clr_r;
  logic [CNT_W-1:0]       pcnt_r;
  logic [15:0]            num_r;
  logic                   new_r, last_r;
  logic [2:0]             ornt_r, lf_r;
  err_t                   err_r;

  shape_t                 shape_c;
  vtx_t                   fv_c [4], srt_in [4], srt_out [4], cv [4];
  logic [KEY_W-1:0]       key_c, order_c;
  logic [HASH_W-1:0]      prod;
  logic [ENTRY_W-1:0]     rd_data, wr_data;
  logic                   e_valid, hit, free, full;
  logic [KEY_W-1:0]       e_key, e_order;
  logic [FNUM_W-1:0]      e_num, new_num;
  logic [3:0]             ornt_c;
  logic                   ram_we;
  logic [SLOT_W-1:0]      wr_addr;
  logic [VERTEX_BITS-1:0] in_vert [MAX_CONE];

  assign in_vert = '{in_vertex_0[VERTEX_BITS-1:0], in_vertex_1[VERTEX_BITS-1:0],
                     in_vertex_2[VERTEX_BITS-1:0], in_vertex_3[VERTEX_BITS-1:0],
                     in_vertex_4[VERTEX_BITS-1:0], in_vertex_5[VERTEX_BITS-1:0],
                     in_vertex_6[VERTEX_BITS-1:0], in_vertex_7[VERTEX_BITS-1:0]};

  // Decode the cell shape and check the face size
  assign shape_c       = shape_decode(dim_r, cs_r);
  assign sts.shape_ok  = (shape_c != SHAPE_NONE);
  assign sts.size_ok   = (seen_r == 3'd0) || (seen_r == face_size(shape_c));
  assign sts.hash_done = (hidx_r == 2'd3);
  assign sts.clr_done  = (clr_r == SLOT_W'(TABLE_ENTRIES - 1));
  assign sts.last      = last_r;

  // Gather face vertices, build sorted key and order
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      fv_c[a]   = (3'(a) < fsize_r) ?
                  16'(vert_r[pat_vertex(shape_r, face_r, 2'(a))]) : 16'd0;
      srt_in[a] = (3'(a) < fsize_r) ? fv_c[a] : 16'hFFFF;
    end
    sort4(srt_in, srt_out);
    for (int a = 0; a < 4; a++) begin
      key_c[16*a +: 16]   = (3'(a) < fsize_r) ? srt_out[a] : 16'd0;
      order_c[16*a +: 16] = fv_c[a];
    end
  end

  // One 16-bit slice of the key times the hash constant per step
  assign prod = HASH_W'(HASH_W'(key_r[16*hidx_r +: 16] * HASH_MULT[HASH_W-1:0])
                        << {hidx_r, 4'b0000});

  // Probe result
  assign {e_valid, e_key, e_order, e_num} = rd_data;
  always_comb begin
    for (int a = 0; a < 4; a++) cv[a] = e_order[16*a +: 16];
  end
  assign hit     = e_valid && (e_key == key_r);
  assign free    = !e_valid;
  assign full    = !hit && !free && (pcnt_r == CNT_W'(TABLE_ENTRIES - 1));
  assign ornt_c  = orient(fv_r, cv, fsize_r);
  assign new_num = FNUM_W'(base_r + 16'(created_r));
  assign sts.probe_done = hit || free || full;

  // Table write: clearing pass or face creation
  assign ram_we  = cmd.clr || (cmd.check && free);
  assign wr_addr = cmd.clr ? clr_r : slot_r;
  assign wr_data = cmd.clr ? '0 : {1'b1, key_r, order_r, new_num};

  mfdo_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  // Control state: configuration, counters, clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r     <= 2'd2;
      base_r    <= 16'd0;
      created_r <= '0;
      seen_r    <= 3'd0;
      clr_r     <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_DIM)  dim_r  <= cfg_data[1:0];
      if (cfg_we && cfg_index == CFG_BASE) base_r <= cfg_data;
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.start) seen_r <= face_size(shape_c);
      if (cmd.check && free) created_r <= created_r + 1'b1;
    end
  end

  // Cell, face, hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load_cell) begin
      cs_r   <= in_cone_size;
      vert_r <= in_vert;
    end
    if (cmd.start) begin
      shape_r  <= shape_c;
      fsize_r  <= face_size(shape_c);
      nfaces_r <= face_count(shape_c);
      face_r   <= 3'd0;
    end
    if (cmd.next_face) face_r <= face_r + 1'b1;
    if (cmd.load_face) begin
      fv_r    <= fv_c;
      key_r   <= key_c;
      order_r <= order_c;
      acc_r   <= '0;
      hidx_r  <= 2'd0;
    end
    if (cmd.hash_step) begin
      acc_r  <= acc_r + prod;
      hidx_r <= hidx_r + 1'b1;
    end
    if (cmd.seed) begin
      slot_r <= acc_r[HASH_W-1:32];
      pcnt_r <= '0;
    end
    if (cmd.check && !sts.probe_done) begin
      slot_r <= slot_r + 1'b1;
      pcnt_r <= pcnt_r + 1'b1;
    end
  end

  // Result register, held while the output is stalled
  always_ff @(posedge clk) begin
    if (cmd.err_shape || cmd.err_size) begin
      num_r  <= 16'd0;
      new_r  <= 1'b0;
      ornt_r <= 3'd0;
      lf_r   <= 3'd0;
      last_r <= 1'b1;
      err_r  <= cmd.err_shape ? ERR_SHAPE : ERR_SIZE;
    end else if (cmd.check && sts.probe_done) begin
      lf_r   <= face_r;
      last_r <= (face_r == nfaces_r - 3'd1);
      priority if (hit) begin
        num_r  <= e_num;
        new_r  <= 1'b0;
        ornt_r <= ornt_c[3] ? 3'd0 : ornt_c[2:0];
        err_r  <= ornt_c[3] ? ERR_ORIENT : ERR_OK;
      end else if (free) begin
        num_r  <= new_num;
        new_r  <= 1'b1;
        ornt_r <= 3'd0;
        err_r  <= ERR_OK;
      end else begin
        num_r  <= 16'd0;
        new_r  <= 1'b0;
        ornt_r <= 3'd0;
        err_r  <= ERR_FULL;
      end
    end
  end

  assign out_face_number = num_r;
  assign out_is_new      = new_r;
  assign out_orientation = ornt_r;
  assign out_local_face  = lf_r;
  assign out_last_face   = last_r;
  assign out_error_code  = err_r;

endmodule
